@@ design/hermite_spline_stream_tessellator_defines.svh @@
// assertion macros used by the tessellator top level
// no dependencies; NO_ASSERTIONS removes every check
`ifndef HERMITE_SPLINE_STREAM_TESSELLATOR_DEFINES_SVH
`define HERMITE_SPLINE_STREAM_TESSELLATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define HSST_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("hsst check failed");
// consequent holds on the edge after the antecedent
`define HSST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hsst check failed");
`else
`define HSST_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define HSST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/hsst_pkg.sv @@
// shared types and constants of the hermite spline tessellator
// no dependencies
package hsst_pkg;

    localparam int COORD_W         = 16;
    localparam int STEP_W          = 7;
    localparam int DEF_MAX_STEPS   = 64;
    localparam int DEF_FRAC_BITS   = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 7'd16;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      final_point;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic signed [COORD_W-1:0] to_x;
        logic signed [COORD_W-1:0] to_y;
        logic                      run_last;
        logic                      curve_last;
    } out_item_t;

    typedef struct packed {
        logic div_start;
        logic t_adv;
        logic sq_en;
        logic cube_en;
        logic h_en;
    } basis_ctrl_t;

    typedef struct packed {
        logic load_first;
        logic load;
        logic run_last;
        logic curve_last;
    } merge_ctrl_t;

endpackage

@@ design/hsst_basis.sv @@
// parameter t generator and hermite basis weights h00 h01 h10 h11
// depends on hsst_pkg
module hsst_basis #(
    parameter int FRAC_BITS = hsst_pkg::DEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  hsst_pkg::basis_ctrl_t             ctrl,
    input  logic [hsst_pkg::STEP_W-1:0]       steps,
    output logic                              div_done,
    output logic [3:0][FRAC_BITS+3:0]         h_flat
);
    localparam int TW = FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 2;
    localparam int DW = hsst_pkg::STEP_W + 1;
    localparam int HW = FRAC_BITS + 4;
    localparam int CW = $clog2(QW + 1);
    localparam logic [2*TW-1:0] HALF = (2*TW)'(1) << (FRAC_BITS - 1);
    localparam logic signed [HW-1:0] ONE = HW'(1) << FRAC_BITS;

    logic [DW-1:0] d_reg, rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   sh;
    logic [TW-1:0] tq_reg, t2_reg, t3_reg;
    logic [DW-1:0] tr_reg;
    logic [DW:0]   rsum;
    logic [2*TW-1:0] sq_prod, cu_prod;
    logic signed [HW-1:0] te, t2e, t3e;
    logic [3:0][HW-1:0] h_reg;

    // restoring division of 2^(F+1) by twice the step count
    always_comb begin
        sh = {rem_reg, (cnt_reg == CW'(QW))};
        if (sh >= {1'b0, d_reg}) begin
            rem_next = DW'(sh - {1'b0, d_reg});
            q_next   = {q_reg[QW-2:0], 1'b1};
        end else begin
            rem_next = sh[DW-1:0];
            q_next   = {q_reg[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (ctrl.div_start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.div_start) begin
            d_reg   <= {steps, 1'b0};
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign div_done = !busy_reg;

    // t walks by quotient and remainder of the step
    assign rsum = {1'b0, tr_reg} + {1'b0, rem_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.div_start) begin
            tq_reg <= '0;
            tr_reg <= {1'b0, steps};
        end else if (ctrl.t_adv) begin
            if (rsum >= {1'b0, d_reg}) begin
                tr_reg <= DW'(rsum - {1'b0, d_reg});
                tq_reg <= tq_reg + q_reg[TW-1:0] + TW'(1);
            end else begin
                tr_reg <= rsum[DW-1:0];
                tq_reg <= tq_reg + q_reg[TW-1:0];
            end
        end
    end

    // square and cube, one multiplier each, registered in successive states
    assign sq_prod = tq_reg * tq_reg + HALF;
    assign cu_prod = t2_reg * tq_reg + HALF;

    always_ff @(posedge aclk) begin
        if (ctrl.sq_en) begin
            t2_reg <= sq_prod[FRAC_BITS +: TW];
        end
        if (ctrl.cube_en) begin
            t3_reg <= cu_prod[FRAC_BITS +: TW];
        end
    end

    // basis weights
    assign te  = HW'(tq_reg);
    assign t2e = HW'(t2_reg);
    assign t3e = HW'(t3_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.h_en) begin
            h_reg[0] <= HW'(2 * t3e - 3 * t2e + ONE);
            h_reg[1] <= HW'(3 * t2e - 2 * t3e);
            h_reg[2] <= HW'(t3e - 2 * t2e + te);
            h_reg[3] <= HW'(t3e - t2e);
        end
    end

    assign h_flat = h_reg;

endmodule

@@ design/hsst_lane.sv @@
// one coordinate lane: multiply-accumulate of four terms, round, saturate
// depends on hsst_pkg
module hsst_lane #(
    parameter int FRAC_BITS = hsst_pkg::DEF_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                mac_en,
    input  logic                                clear,
    input  logic signed [hsst_pkg::COORD_W:0]   coef,
    input  logic signed [FRAC_BITS+3:0]         weight,
    output logic signed [hsst_pkg::COORD_W-1:0] result
);
    localparam int CW  = hsst_pkg::COORD_W;
    localparam int HW  = FRAC_BITS + 4;
    localparam int PW  = CW + 1 + HW;
    localparam int AW  = PW + 2;
    localparam int SW  = AW - FRAC_BITS;
    localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] HI = SW'((1 << (CW - 1)) - 1);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);

    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] acc_reg, acc_next, rnd;
    logic signed [SW-1:0] shifted;

    // accumulate one term per cycle while mac_en is high
    assign prod     = PW'(coef) * PW'(weight);
    assign acc_next = (clear ? AW'(0) : acc_reg) + AW'(prod);

    always_ff @(posedge aclk) begin
        if (mac_en) begin
            acc_reg <= acc_next;
        end
    end

    // round half up, then clamp to coordinate range
    assign rnd     = acc_reg + HALF;
    assign shifted = SW'(rnd >>> FRAC_BITS);

    always_comb begin
        if (shifted > HI) begin
            result = HI[CW-1:0];
        end else if (shifted < LO) begin
            result = LO[CW-1:0];
        end else begin
            result = shifted[CW-1:0];
        end
    end

endmodule

@@ design/hsst_merge.sv @@
// merge stage: joins lane results into line segments and holds the output
// depends on hsst_pkg
module hsst_merge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hsst_pkg::merge_ctrl_t               ctrl,
    input  logic signed [hsst_pkg::COORD_W-1:0] start_x,
    input  logic signed [hsst_pkg::COORD_W-1:0] start_y,
    input  logic signed [hsst_pkg::COORD_W-1:0] lane_x,
    input  logic signed [hsst_pkg::COORD_W-1:0] lane_y,
    output logic                                slot_free,
    output hsst_pkg::out_item_t                 m_data,
    output logic                                m_valid,
    input  logic                                m_ready
);
    logic signed [hsst_pkg::COORD_W-1:0] from_x_reg, from_y_reg;
    hsst_pkg::out_item_t out_reg;
    logic valid_reg;

    assign slot_free = !valid_reg || m_ready;

    // segment start tracking
    always_ff @(posedge aclk) begin
        if (ctrl.load_first) begin
            from_x_reg <= start_x;
            from_y_reg <= start_y;
        end else if (ctrl.load) begin
            from_x_reg <= lane_x;
            from_y_reg <= lane_y;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            out_reg.from_x     <= from_x_reg;
            out_reg.from_y     <= from_y_reg;
            out_reg.to_x       <= lane_x;
            out_reg.to_y       <= lane_y;
            out_reg.run_last   <= ctrl.run_last;
            out_reg.curve_last <= ctrl.curve_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = valid_reg;

endmodule

@@ design/hermite_spline_stream_tessellator.sv @@
// top level of the streaming hermite spline tessellator
// depends on hsst_pkg, hsst_basis, hsst_lane, hsst_merge and the defines header
//
// Usage: control points enter on s_valid/s_ready/s_data, one per transfer.
// Each point from the fourth on produces step_count line segments on
// m_valid/m_ready/m_data; earlier points only fill the three-point window.
// A point flagged final ends the curve and empties the window.
// step_count is to be written on cfg_valid/cfg_ready/cfg_data while idle;
// the block itself does not enforce this. 0 acts as 1 and values above
// MAX_STEPS act as MAX_STEPS. A point that only fills the window leaves
// the sequencer idle. A point that emits runs the step division, then per
// segment t advance, square, cube, basis, four multiply-accumulate steps in
// the x and y lanes and output load; no new point is taken before its last segment is loaded.
// The single lane multiplier per coordinate sets the per-segment cost.
// The last segment sits in the output register while the next point is taken.
// Reset clears the window count, the step count (to 16) and the output valid.
// When the receiver stalls, work pauses at the output load until it drains.
module hermite_spline_stream_tessellator #(
    parameter int MAX_STEPS = hsst_pkg::DEF_MAX_STEPS,
    parameter int FRAC_BITS = hsst_pkg::DEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  hsst_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hsst_pkg::out_item_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hsst_pkg::STEP_W-1:0]   cfg_data
);
`include "hermite_spline_stream_tessellator_defines.svh"

    localparam int CW = hsst_pkg::COORD_W;
    localparam int SWD = hsst_pkg::STEP_W;
    localparam int HW = FRAC_BITS + 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ADV  = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_CUBE = 3'd4;
    localparam logic [2:0] S_HB   = 3'd5;
    localparam logic [2:0] S_MAC  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [SWD-1:0] step_reg, steps_eff, n_reg, j_reg;
    logic [1:0] held_reg, phase_reg;
    logic fin_reg;
    logic signed [CW-1:0] wx_reg [3];
    logic signed [CW-1:0] wy_reg [3];
    logic signed [CW:0] opx_reg [4];
    logic signed [CW:0] opy_reg [4];
    logic in_acc, emit, div_done, slot_free, seg_last;
    logic signed [CW-1:0] res_x, res_y;
    logic [3:0][HW-1:0] h_flat;
    hsst_pkg::basis_ctrl_t bctl;
    hsst_pkg::merge_ctrl_t mctl;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= hsst_pkg::STEP_RESET;
        end else if (cfg_valid) begin
            step_reg <= cfg_data;
        end
    end

    always_comb begin
        if (step_reg == '0) begin
            steps_eff = SWD'(1);
        end else if (step_reg > SWD'(MAX_STEPS)) begin
            steps_eff = SWD'(MAX_STEPS);
        end else begin
            steps_eff = step_reg;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign in_acc  = s_valid && s_ready;
    assign emit    = (held_reg == 2'd3);

    // point window and operand capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (in_acc) begin
            if (s_data.final_point) begin
                held_reg <= '0;
            end else if (!emit) begin
                held_reg <= held_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            if (emit) begin
                wx_reg[0] <= wx_reg[1];
                wy_reg[0] <= wy_reg[1];
                wx_reg[1] <= wx_reg[2];
                wy_reg[1] <= wy_reg[2];
                wx_reg[2] <= s_data.point_x;
                wy_reg[2] <= s_data.point_y;
                opx_reg[0] <= (CW+1)'(wx_reg[1]);
                opy_reg[0] <= (CW+1)'(wy_reg[1]);
                opx_reg[1] <= (CW+1)'(wx_reg[2]);
                opy_reg[1] <= (CW+1)'(wy_reg[2]);
                opx_reg[2] <= (CW+1)'(wx_reg[1]) - (CW+1)'(wx_reg[0]);
                opy_reg[2] <= (CW+1)'(wy_reg[1]) - (CW+1)'(wy_reg[0]);
                if (s_data.final_point) begin
                    opx_reg[3] <= (CW+1)'(s_data.point_x) - (CW+1)'(wx_reg[2]);
                    opy_reg[3] <= (CW+1)'(s_data.point_y) - (CW+1)'(wy_reg[2]);
                end else begin
                    opx_reg[3] <= (CW+1)'(wx_reg[2]) - (CW+1)'(wx_reg[1]);
                    opy_reg[3] <= (CW+1)'(wy_reg[2]) - (CW+1)'(wy_reg[1]);
                end
                fin_reg <= s_data.final_point;
                n_reg   <= steps_eff;
            end else begin
                wx_reg[held_reg] <= s_data.point_x;
                wy_reg[held_reg] <= s_data.point_y;
            end
        end
    end

    // segment sequencer
    assign seg_last = (j_reg == n_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc && emit) state_next = S_DIV;
            S_DIV:  if (div_done) state_next = S_ADV;
            S_ADV:  state_next = S_SQ;
            S_SQ:   state_next = S_CUBE;
            S_CUBE: state_next = S_HB;
            S_HB:   state_next = S_MAC;
            S_MAC:  if (phase_reg == 2'd3) state_next = S_OUT;
            S_OUT: begin
                if (slot_free) state_next = seg_last ? S_IDLE : S_ADV;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_MAC) begin
                phase_reg <= phase_reg + 2'd1;
            end
            if (in_acc) begin
                j_reg <= '0;
            end else if (state_reg == S_ADV) begin
                j_reg <= j_reg + SWD'(1);
            end
        end
    end

    always_comb begin
        bctl.div_start = in_acc && emit;
        bctl.t_adv     = (state_reg == S_ADV);
        bctl.sq_en     = (state_reg == S_SQ);
        bctl.cube_en   = (state_reg == S_CUBE);
        bctl.h_en      = (state_reg == S_HB);
        mctl.load_first = in_acc && emit;
        mctl.load       = (state_reg == S_OUT) && slot_free;
        mctl.run_last   = seg_last;
        mctl.curve_last = seg_last && fin_reg;
    end

    hsst_basis #(.FRAC_BITS(FRAC_BITS)) u_basis (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (bctl),
        .steps    (steps_eff),
        .div_done (div_done),
        .h_flat   (h_flat)
    );

    hsst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .aclk   (aclk),
        .mac_en (state_reg == S_MAC),
        .clear  (phase_reg == 2'd0),
        .coef   (opx_reg[phase_reg]),
        .weight (h_flat[phase_reg]),
        .result (res_x)
    );

    hsst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .aclk   (aclk),
        .mac_en (state_reg == S_MAC),
        .clear  (phase_reg == 2'd0),
        .coef   (opy_reg[phase_reg]),
        .weight (h_flat[phase_reg]),
        .result (res_y)
    );

    hsst_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mctl),
        .start_x   (wx_reg[1]),
        .start_y   (wy_reg[1]),
        .lane_x    (res_x),
        .lane_y    (res_y),
        .slot_free (slot_free),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

    // checks
    `HSST_ASSERT_NEXT(a_final_clears, aclk, aresetn, in_acc && s_data.final_point, held_reg == 2'd0)
    `HSST_ASSERT_ALWAYS(a_curve_implies_run, aclk, aresetn, !m_valid || !m_data.curve_last || m_data.run_last)
    `HSST_ASSERT_ALWAYS(a_load_slot_free, aclk, aresetn, !mctl.load || !m_valid || m_ready)
    `HSST_ASSERT_ALWAYS(a_seg_count, aclk, aresetn, state_reg == S_IDLE || j_reg <= n_reg)

endmodule

@@ dv/tb_hermite_spline_stream_tessellator.sv @@
// self-checking testbench for hermite_spline_stream_tessellator
// depends on hsst_pkg and the tessellator rtl; predicts every line segment in place
`timescale 1ns / 100ps

module tb_hermite_spline_stream_tessellator;

    localparam int IDLE_CYCLES     = 800;
    localparam int FRAC            = 16;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    hsst_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    hsst_pkg::out_item_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [hsst_pkg::STEP_W-1:0] cfg_data = '0;

    // pending control points, expected line segments
    hsst_pkg::in_item_t  point_queue[$];
    hsst_pkg::out_item_t segment_queue[$];

    // predictor state
    longint          win_x[3];
    longint          win_y[3];
    int              held_points;
    logic [hsst_pkg::STEP_W-1:0] step_reg;

    int  error_count = 0;
    int  accepted_points = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    int  stall_mode = 0;
    int  cycle_count = 0;

    hermite_spline_stream_tessellator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp_coord(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint curve_coord(longint p1, longint p2, longint r1, longint r2,
                                           longint h0, longint h1, longint h2, longint h3);
        longint acc;
        acc = p1 * h0 + p2 * h1 + r1 * h2 + r2 * h3 + (longint'(1) << (FRAC - 1));
        return clamp_coord(acc >>> FRAC);
    endfunction

    // push the segments that one accepted control point causes
    function automatic void tessellate_point(hsst_pkg::in_item_t p);
        longint nx, ny, r1x, r1y, r2x, r2y, fx, fy, tx, ty;
        longint n, t, t2, t3, h0, h1, h2, h3;
        hsst_pkg::out_item_t seg;
        nx = longint'(p.point_x);
        ny = longint'(p.point_y);
        if (held_points >= 3) begin
            n = step_reg;
            if (n < 1) n = 1;
            if (n > hsst_pkg::DEF_MAX_STEPS) n = hsst_pkg::DEF_MAX_STEPS;
            r1x = win_x[1] - win_x[0];
            r1y = win_y[1] - win_y[0];
            if (p.final_point) begin
                r2x = nx - win_x[2];
                r2y = ny - win_y[2];
            end else begin
                r2x = win_x[2] - win_x[1];
                r2y = win_y[2] - win_y[1];
            end
            fx = win_x[1];
            fy = win_y[1];
            for (longint j = 1; j <= n; j++) begin
                t  = (j * 65536 * 2 + n) / (2 * n);
                t2 = (t * t + 32768) >>> FRAC;
                t3 = (t2 * t + 32768) >>> FRAC;
                h0 = 2 * t3 - 3 * t2 + 65536;
                h1 = -2 * t3 + 3 * t2;
                h2 = t3 - 2 * t2 + t;
                h3 = t3 - t2;
                tx = curve_coord(win_x[1], win_x[2], r1x, r2x, h0, h1, h2, h3);
                ty = curve_coord(win_y[1], win_y[2], r1y, r2y, h0, h1, h2, h3);
                seg.from_x     = fx[15:0];
                seg.from_y     = fy[15:0];
                seg.to_x       = tx[15:0];
                seg.to_y       = ty[15:0];
                seg.run_last   = (j == n);
                seg.curve_last = (j == n) && p.final_point;
                segment_queue.push_back(seg);
                fx = tx;
                fy = ty;
            end
            win_x[0] = win_x[1]; win_y[0] = win_y[1];
            win_x[1] = win_x[2]; win_y[1] = win_y[2];
            win_x[2] = nx;       win_y[2] = ny;
        end else begin
            win_x[held_points] = nx;
            win_y[held_points] = ny;
            held_points++;
        end
        if (p.final_point) held_points = 0;
    endfunction

    // driver: bursts of transfers with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tessellate_point(s_data);
                accepted_points++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (point_queue.size() > 0) begin
                    s_data  <= point_queue.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off while points keep coming
    always @(posedge aclk) begin
        cycle_count++;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && accepted_points >= 60) begin
            hold_done = 1;
            hold_left = 3000;
            m_ready <= 1'b0;
        end else begin
            if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 1) == 1);
                end
                2: begin
                    m_ready <= (cycle_count % 7) > 1;
                end
                default: begin
                    m_ready <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // monitor: compare each segment transfer with the oldest expectation
    always @(posedge aclk) begin
        hsst_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (segment_queue.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected segment %p", m_data);
            end else begin
                want = segment_queue.pop_front();
                if (m_data.from_x !== want.from_x || m_data.from_y !== want.from_y ||
                    m_data.to_x !== want.to_x || m_data.to_y !== want.to_y ||
                    m_data.run_last !== want.run_last ||
                    m_data.curve_last !== want.curve_last) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("segment mismatch: expected %p actual %p", want, m_data);
                end
            end
        end
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            1: return 16'($signed($urandom_range(0, 200)) - 100);
            2: return 16'($signed($urandom_range(0, 8000)) - 4000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_point(logic [15:0] x, logic [15:0] y, logic fin);
        hsst_pkg::in_item_t p;
        p.point_x     = x;
        p.point_y     = y;
        p.final_point = fin;
        point_queue.push_back(p);
    endfunction

    // mostly whole curves, some short broken ones and stray points
    function automatic void add_random_points(int count);
        int len;
        while (count > 0) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(1, 3);
                1: len = 1;
                default: len = $urandom_range(4, 10);
            endcase
            for (int k = 0; k < len && count > 0; k++) begin
                add_point(pick_coord(), pick_coord(),
                          (k == len - 1) && ($urandom_range(0, 9) != 0));
                count--;
            end
        end
    endfunction

    // sample on the falling edge so that driver updates have settled
    task automatic wait_idle();
        while (point_queue.size() > 0 || s_valid || segment_queue.size() > 0)
            @(negedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_steps(logic [hsst_pkg::STEP_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        step_reg = v;
    endtask

    // stimulus sequence and end of run
    initial begin
        logic [hsst_pkg::STEP_W-1:0] phase_steps[7] =
            '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65, 7'd3, 7'd5};
        step_reg    = hsst_pkg::STEP_RESET;
        held_points = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: lone final, one point then final, final as third point
        add_point(16'h0001, 16'hffff, 1'b1);
        add_point(16'h7fff, 16'h8000, 1'b0);
        add_point(16'h8000, 16'h7fff, 1'b1);
        add_point(16'h0000, 16'h0000, 1'b0);
        add_point(16'h0010, 16'h0020, 1'b0);
        add_point(16'hfff0, 16'h0040, 1'b1);
        // saturating swings at full range, final on the fourth point
        add_point(16'h7fff, 16'h7fff, 1'b0);
        add_point(16'h8000, 16'h8000, 1'b0);
        add_point(16'h7fff, 16'h7fff, 1'b0);
        add_point(16'h8000, 16'h8000, 1'b1);
        // longer curve, running on past the window, then a four-point curve
        add_point(16'h8000, 16'h7fff, 1'b0);
        add_point(16'h7fff, 16'h8000, 1'b0);
        add_point(16'h8000, 16'h7fff, 1'b0);
        add_point(16'h7fff, 16'h8000, 1'b0);
        add_point(16'h0000, 16'hffff, 1'b0);
        add_point(16'hffff, 16'h0000, 1'b0);
        add_point(16'h5555, 16'haaaa, 1'b1);
        add_point(16'haaaa, 16'h5555, 1'b0);
        add_point(16'h0100, 16'hff00, 1'b0);
        add_point(16'h0200, 16'hfe00, 1'b0);
        add_point(16'h0300, 16'hfd00, 1'b1);
        add_random_points(60);

        foreach (phase_steps[i]) begin
            wait_idle();
            write_steps(phase_steps[i]);
            if (phase_steps[i] >= 7'd64)
                add_random_points(8);
            else
                add_random_points(30);
        end
        wait_idle();
        write_steps(7'($urandom_range(2, 8)));
        add_random_points(54);
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ hermite_spline_stream_tessellator.f @@
+incdir+design
design/hsst_pkg.sv
design/hsst_basis.sv
design/hsst_lane.sv
design/hsst_merge.sv
design/hermite_spline_stream_tessellator.sv
dv/tb_hermite_spline_stream_tessellator.sv
